// File: rtl/rta_pkg.sv
// shared types, codes and constants of the record table allocator
`default_nettype none

package rta_pkg;

   localparam int RECORDS_DEFAULT         = 4096;
   localparam int FLAG_BITS_DEFAULT       = 8;
   localparam int GENERATION_BITS_DEFAULT = 32;

   localparam int BLOCK_BITS  = 64;
   localparam int CAP_BITS    = 13;
   localparam int COUNT_BITS  = 13;
   localparam int STATUS_BITS = 3;
   localparam int OP_BITS     = 2;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 13'd4096;

   typedef enum logic [OP_BITS-1:0] {
      OP_ALLOC   = 2'd0,
      OP_UPDATE  = 2'd1,
      OP_FREE    = 2'd2,
      OP_RESOLVE = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK       = 3'd0,
      ST_INVALID  = 3'd1,
      ST_NOSPACE  = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_UNBOUND  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR  = 2'd0,
      S_IDLE   = 2'd1,
      S_SCAN   = 2'd2,
      S_COMMIT = 2'd3
   } state_type;

endpackage

`default_nettype wire

// File: rtl/rta_table.sv
// record table storage: one write port, one registered read port
`default_nettype none

module rta_table #(
   parameter int DEPTH     = rta_pkg::RECORDS_DEFAULT,
   parameter int ADDR_BITS = $clog2(rta_pkg::RECORDS_DEFAULT),
   parameter int DATA_BITS = rta_pkg::BLOCK_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] table_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/record_table_allocator.sv
// top level of the record table allocator: sequencer, counter and response register
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  operation, slot_id, new_block, set_flags
//   rsp      out        rsp_valid / rsp_stall  status, result_id, mapped_block,
//                                              entry_flags, entry_generation, free_records
//   csr      in         csr_wr_en              csr_wr_data (capacity_records)
//
// update, free, resolve and invalid ids: one table read on acceptance, then one commit; an invalid id skips the read
// allocate reads one entry a cycle from id 1 up and takes the first free entry;
// it answers no space when no entry below the capacity is free, and at once below a capacity of 2
// after reset a clearing pass writes every entry; req_stall is high
// a stalled response holds the commit of the next transaction, not its acceptance
`default_nettype none

module record_table_allocator #(
   parameter int RECORDS         = rta_pkg::RECORDS_DEFAULT,
   parameter int FLAG_BITS       = rta_pkg::FLAG_BITS_DEFAULT,
   parameter int GENERATION_BITS = rta_pkg::GENERATION_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [rta_pkg::OP_BITS-1:0]          req_operation,
   input  wire logic [$clog2(RECORDS)-1:0]           req_slot_id,
   input  wire logic [rta_pkg::BLOCK_BITS-1:0]       req_new_block,
   input  wire logic [FLAG_BITS-1:0]                 req_set_flags,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [rta_pkg::STATUS_BITS-1:0]           rsp_status,
   output logic [$clog2(RECORDS)-1:0]                rsp_result_id,
   output logic [rta_pkg::BLOCK_BITS-1:0]            rsp_mapped_block,
   output logic [FLAG_BITS-1:0]                      rsp_entry_flags,
   output logic [GENERATION_BITS-1:0]                rsp_entry_generation,
   output logic [rta_pkg::COUNT_BITS-1:0]            rsp_free_records,
   input  wire logic                                 csr_wr_en,
   input  wire logic [rta_pkg::CAP_BITS-1:0]         csr_wr_data
);

   localparam int ID_BITS    = $clog2(RECORDS);
   localparam int BLK        = rta_pkg::BLOCK_BITS;
   localparam int DATA_BITS  = BLK + FLAG_BITS + GENERATION_BITS;
   localparam int CMP_BITS   = (ID_BITS + 1 > rta_pkg::CAP_BITS) ? ID_BITS + 1
                                                                  : rta_pkg::CAP_BITS;
   localparam int CNT        = rta_pkg::COUNT_BITS;

   rta_pkg::state_type            state_ff, state_in;
   logic [ID_BITS-1:0]            clr_ff, clr_in;
   rta_pkg::op_type               op_ff, op_in;
   logic [BLK-1:0]                blk_ff, blk_in;
   logic [FLAG_BITS-1:0]          set_ff, set_in;
   logic [ID_BITS-1:0]            chk_addr_ff, chk_addr_in;
   logic                          chk_vld_ff, chk_vld_in;
   logic [ID_BITS:0]              scan_ff, scan_in;
   logic                          bad_ff, bad_in;
   logic [rta_pkg::CAP_BITS-1:0]  cap_ff, cap_in;
   logic [CNT-1:0]                cnt_ff, cnt_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   rta_pkg::status_type           st_ff, st_in;
   logic [ID_BITS-1:0]            rid_ff, rid_in;
   logic [BLK-1:0]                mblk_ff, mblk_in;
   logic [FLAG_BITS-1:0]          mflg_ff, mflg_in;
   logic [GENERATION_BITS-1:0]    mgen_ff, mgen_in;
   logic [CNT-1:0]                mcnt_ff, mcnt_in;

   logic                          wr_en, rd_en;
   logic [ID_BITS-1:0]            wr_addr, rd_addr;
   logic [DATA_BITS-1:0]          wr_data, rd_data;
   logic [BLK-1:0]                rd_blk;
   logic [FLAG_BITS-1:0]          rd_flg;
   logic [GENERATION_BITS-1:0]    rd_gen;

   logic [CMP_BITS-1:0]           cap_ext, cap_eff;
   logic                          id_ok, scan_more, slot_free;

   rta_table #(
      .DEPTH     (RECORDS),
      .ADDR_BITS (ID_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_blk = rd_data[BLK-1:0];
   assign rd_flg = rd_data[BLK+FLAG_BITS-1:BLK];
   assign rd_gen = rd_data[DATA_BITS-1:BLK+FLAG_BITS];

   assign cap_ext   = CMP_BITS'(cap_ff);
   assign cap_eff   = (cap_ext > CMP_BITS'(RECORDS)) ? CMP_BITS'(RECORDS) : cap_ext;
   assign id_ok     = CMP_BITS'(req_slot_id) < cap_eff;
   assign scan_more = CMP_BITS'(scan_ff) < cap_eff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign cap_in    = csr_wr_en ? csr_wr_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rta_pkg::S_CLEAR;
         clr_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         cap_ff       <= rta_pkg::CAP_RESET;
         cnt_ff       <= CNT'(RECORDS - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chk_vld_ff   <= chk_vld_in;
         cap_ff       <= cap_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      blk_ff      <= blk_in;
      set_ff      <= set_in;
      chk_addr_ff <= chk_addr_in;
      scan_ff     <= scan_in;
      bad_ff      <= bad_in;
      st_ff       <= st_in;
      rid_ff      <= rid_in;
      mblk_ff     <= mblk_in;
      mflg_ff     <= mflg_in;
      mgen_ff     <= mgen_in;
      mcnt_ff     <= mcnt_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      blk_in       = blk_ff;
      set_in       = set_ff;
      chk_addr_in  = chk_addr_ff;
      chk_vld_in   = chk_vld_ff;
      scan_in      = scan_ff;
      bad_in       = bad_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      st_in        = st_ff;
      rid_in       = rid_ff;
      mblk_in      = mblk_ff;
      mflg_in      = mflg_ff;
      mgen_in      = mgen_ff;
      mcnt_in      = mcnt_ff;
      rd_en        = 1'b0;
      rd_addr      = chk_addr_ff;
      wr_en        = 1'b0;
      wr_addr      = chk_addr_ff;
      wr_data      = rd_data;
      req_stall    = 1'b1;

      case (state_ff)
         rta_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {{GENERATION_BITS{1'b0}}, {FLAG_BITS{1'b0}}, {BLK{1'b1}}};
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == ID_BITS'(RECORDS - 1)) begin
               state_in = rta_pkg::S_IDLE;
            end
         end
         rta_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in       = rta_pkg::op_type'(req_operation);
               blk_in      = req_new_block;
               set_in      = req_set_flags;
               chk_addr_in = req_slot_id;
               chk_vld_in  = 1'b0;
               scan_in     = (ID_BITS + 1)'(1);
               bad_in      = 1'b0;
               if (rta_pkg::op_type'(req_operation) == rta_pkg::OP_ALLOC) begin
                  state_in = rta_pkg::S_SCAN;
               end else if (!id_ok) begin
                  bad_in   = 1'b1;
                  state_in = rta_pkg::S_COMMIT;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = req_slot_id;
                  state_in = rta_pkg::S_COMMIT;
               end
            end
         end
         rta_pkg::S_SCAN: begin
            if (chk_vld_ff && !rd_flg[0]) begin
               state_in = rta_pkg::S_COMMIT;
            end else if (scan_more) begin
               rd_en       = 1'b1;
               rd_addr     = scan_ff[ID_BITS-1:0];
               chk_addr_in = scan_ff[ID_BITS-1:0];
               chk_vld_in  = 1'b1;
               scan_in     = scan_ff + 1'b1;
            end else begin
               bad_in   = 1'b1;
               state_in = rta_pkg::S_COMMIT;
            end
         end
         rta_pkg::S_COMMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = rta_pkg::S_IDLE;
               st_in        = rta_pkg::ST_OK;
               rid_in       = '0;
               mblk_in      = '0;
               mflg_in      = '0;
               mgen_in      = '0;
               case (op_ff)
                  rta_pkg::OP_ALLOC: begin
                     if (bad_ff) begin
                        st_in = rta_pkg::ST_NOSPACE;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = {rd_gen + 1'b1, rd_flg | FLAG_BITS'(1), {BLK{1'b1}}};
                        cnt_in  = cnt_ff - 1'b1;
                        rid_in  = chk_addr_ff;
                        mgen_in = rd_gen + 1'b1;
                     end
                  end
                  rta_pkg::OP_UPDATE: begin
                     if (bad_ff) begin
                        st_in = rta_pkg::ST_INVALID;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = {rd_gen, rd_flg | set_ff, blk_ff};
                     end
                  end
                  rta_pkg::OP_FREE: begin
                     if (bad_ff) begin
                        st_in = rta_pkg::ST_INVALID;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = {rd_gen, {FLAG_BITS{1'b0}}, {BLK{1'b1}}};
                        cnt_in  = cnt_ff + 1'b1;
                     end
                  end
                  rta_pkg::OP_RESOLVE: begin
                     if (bad_ff) begin
                        st_in = rta_pkg::ST_INVALID;
                     end else if (!rd_flg[0]) begin
                        st_in = rta_pkg::ST_NOTFOUND;
                     end else if (rd_blk == '0 || rd_blk == {BLK{1'b1}}) begin
                        st_in = rta_pkg::ST_UNBOUND;
                     end else begin
                        mblk_in = rd_blk;
                        mflg_in = rd_flg;
                        mgen_in = rd_gen;
                     end
                  end
                  default: begin
                     st_in = rta_pkg::ST_INVALID;
                  end
               endcase
               mcnt_in = cnt_in;
            end
         end
         default: begin
            state_in = rta_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = st_ff;
   assign rsp_result_id        = rid_ff;
   assign rsp_mapped_block     = mblk_ff;
   assign rsp_entry_flags      = mflg_ff;
   assign rsp_entry_generation = mgen_ff;
   assign rsp_free_records     = mcnt_ff;

endmodule

`default_nettype wire
